[sv/qte_pkg.sv]
`default_nettype none

package qte_pkg;

  // Fixed widths of the fields and registers
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DataW           = 32;
  // Derivative coefficients reach 20 * a5, which needs 37 signed bits
  localparam int unsigned CoefW           = 37;
  localparam int unsigned NumCoef         = 6;
  localparam int unsigned CfgIdxW         = 3;
  localparam logic [CfgIdxW-1:0] CoefIdxLast = CfgIdxW'(NumCoef - 1);

  // One Horner step per cell; position needs five steps
  localparam int unsigned NumCells = 5;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned LanePos  = 0;
  localparam int unsigned LaneVel  = 1;
  localparam int unsigned LaneAcc  = 2;

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  // Data handed from one cell to the next
  typedef struct packed {
    logic                               valid;
    logic                               ovf;
    logic [DataW-1:0]                   t;
    logic [NumLanes-1:0][DataW-1:0]     acc;
  } qte_link_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > S32Max) begin
      r = S32Max[DataW-1:0];
    end else if (v < S32Min) begin
      r = S32Min[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // High when sat32 changes the value
  function automatic logic sat_hit(input logic signed [63:0] v);
    return (v > S32Max) || (v < S32Min);
  endfunction

endpackage

`default_nettype wire

[sv/qte_cell.sv]
`default_nettype none

// One Horner step for all three lanes: clamp and multiply by t, then
// round, add the next coefficient and clamp again.
module qte_cell import qte_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire qte_link_t               link_i,
  input  wire logic [NumLanes-1:0]     seed_sel_i,
  input  wire logic [NumLanes-1:0]     active_i,
  input  wire logic signed [CoefW-1:0] seed_i   [NumLanes],
  input  wire logic signed [CoefW-1:0] addend_i [NumLanes],
  output qte_link_t                    link_o
);

  localparam logic signed [63:0] RoundHalf = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0]       seed_ext [NumLanes];
  logic signed [DataW-1:0]  mul_in   [NumLanes];
  logic [NumLanes-1:0]      seed_ovf;
  logic signed [DataW-1:0]  t_s;

  logic signed [63:0]       prod_d   [NumLanes];
  logic signed [63:0]       prod_q   [NumLanes];
  logic                     v1_q;
  logic                     ovf1_q;
  logic [DataW-1:0]         t1_q;

  logic signed [63:0]       addend_ext [NumLanes];
  logic signed [63:0]       sum        [NumLanes];
  logic [NumLanes-1:0]      sum_ovf;
  qte_link_t                link_d;
  qte_link_t                link_q;

  // Multiply stage: a lane either starts here from its seed or continues
  always_comb begin
    t_s = $signed(link_i.t);
    for (int l = 0; l < NumLanes; l++) begin
      seed_ext[l] = {{(64 - CoefW){seed_i[l][CoefW-1]}}, seed_i[l]};
      mul_in[l]   = seed_sel_i[l] ? sat32(seed_ext[l]) : $signed(link_i.acc[l]);
      seed_ovf[l] = seed_sel_i[l] & sat_hit(seed_ext[l]);
      prod_d[l]   = 64'(mul_in[l]) * 64'(t_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf1_q <= link_i.ovf | (|seed_ovf);
    t1_q   <= link_i.t;
    for (int l = 0; l < NumLanes; l++) begin
      prod_q[l] <= prod_d[l];
    end
  end

  // Add stage: round to nearest (ties up), add coefficient, clamp
  always_comb begin
    link_d       = '0;
    link_d.valid = v1_q;
    link_d.t     = t1_q;
    for (int l = 0; l < NumLanes; l++) begin
      addend_ext[l] = {{(64 - CoefW){addend_i[l][CoefW-1]}}, addend_i[l]};
      sum[l]        = ((prod_q[l] + RoundHalf) >>> FRAC_BITS) + addend_ext[l];
      sum_ovf[l]    = active_i[l] & sat_hit(sum[l]);
      link_d.acc[l] = sat32(sum[l]);
    end
    link_d.ovf = ovf1_q | (|sum_ovf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

`default_nettype wire

[sv/quintic_trajectory_evaluator.sv]
`default_nettype none

// Quintic trajectory evaluator.
// Coefficients a0..a5 (signed Q16.16) are loaded through the write port:
// cfg_we_i with cfg_idx_i 0..5 writes coef_0..coef_5; other indexes are
// dropped. Write only while no evaluation is in flight.
// A sample time is taken at each clock edge with start high and busy low.
// busy is always low, so a new sample may follow every cycle.
// Each sample gives position, velocity and acceleration, each saturated to
// 32 bits, plus an overflow flag set if any intermediate or final clamp hit.
// Throughput: one sample per cycle. Each sample passes a chain of five
// Horner cells with a multiply stage and an add/clamp stage each.
// Results appear on the output ports for exactly one cycle marked by
// done_o; the receiver has no stall, each transfer is final.
// Reset clears the coefficients to zero and drops all samples in flight.
module quintic_trajectory_evaluator import qte_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [DataW-1:0]    cfg_data_i,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [DataW-1:0] sample_time_i,
  output logic                     done_o,
  output logic signed [DataW-1:0]  position_o,
  output logic signed [DataW-1:0]  velocity_o,
  output logic signed [DataW-1:0]  acceleration_o,
  output logic                     overflow_o
);

  logic [DataW-1:0]          coef_q [NumCoef];
  logic signed [CoefW-1:0]   a      [NumCoef];

  logic [NumLanes-1:0]       seed_sel [NumCells];
  logic [NumLanes-1:0]       active   [NumCells];
  logic signed [CoefW-1:0]   seed     [NumCells][NumLanes];
  logic signed [CoefW-1:0]   addend   [NumCells][NumLanes];

  qte_link_t                 link [NumCells+1];

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= CoefIdxLast)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Per-cell seeds and addends; velocity starts one step later, acceleration two
  always_comb begin
    for (int i = 0; i < NumCoef; i++) begin
      a[i] = {{(CoefW - DataW){coef_q[i][DataW-1]}}, coef_q[i]};
    end
    for (int j = 0; j < NumCells; j++) begin
      seed_sel[j] = '0;
      active[j]   = '0;
      for (int l = 0; l < NumLanes; l++) begin
        seed[j][l]   = '0;
        addend[j][l] = '0;
      end
    end

    seed_sel[0][LanePos] = 1'b1;
    seed[0][LanePos]     = a[5];
    seed_sel[1][LaneVel] = 1'b1;
    seed[1][LaneVel]     = a[5] * 37'sd5;
    seed_sel[2][LaneAcc] = 1'b1;
    seed[2][LaneAcc]     = a[5] * 37'sd20;

    for (int j = 0; j < NumCells; j++) begin
      active[j][LanePos] = 1'b1;
      active[j][LaneVel] = (j >= 1);
      active[j][LaneAcc] = (j >= 2);
    end

    addend[0][LanePos] = a[4];
    addend[1][LanePos] = a[3];
    addend[2][LanePos] = a[2];
    addend[3][LanePos] = a[1];
    addend[4][LanePos] = a[0];

    addend[1][LaneVel] = a[4] * 37'sd4;
    addend[2][LaneVel] = a[3] * 37'sd3;
    addend[3][LaneVel] = a[2] * 37'sd2;
    addend[4][LaneVel] = a[1];

    addend[2][LaneAcc] = a[4] * 37'sd12;
    addend[3][LaneAcc] = a[3] * 37'sd6;
    addend[4][LaneAcc] = a[2] * 37'sd2;
  end

  // Chain entry: every start is a transfer
  assign busy = 1'b0;

  always_comb begin
    link[0]       = '0;
    link[0].valid = start & ~busy;
    link[0].t     = sample_time_i;
  end

  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    qte_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .link_i     (link[j]),
      .seed_sel_i (seed_sel[j]),
      .active_i   (active[j]),
      .seed_i     (seed[j]),
      .addend_i   (addend[j]),
      .link_o     (link[j+1])
    );
  end

  // Last cell registers drive the result ports
  assign done_o         = link[NumCells].valid;
  assign position_o     = $signed(link[NumCells].acc[LanePos]);
  assign velocity_o     = $signed(link[NumCells].acc[LaneVel]);
  assign acceleration_o = $signed(link[NumCells].acc[LaneAcc]);
  assign overflow_o     = link[NumCells].ovf;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
  import qte_pkg::*;

  // Register map of the coefficient write port; the two top indexes are dropped
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5,
    REG_SPARE_6, REG_SPARE_7
  } reg_idx_e;

  // One evaluation: position, velocity, acceleration and the saturation flag
  typedef struct packed {
    logic [DataW-1:0] pos;
    logic [DataW-1:0] vel;
    logic [DataW-1:0] acc;
    logic             ovf;
  } motion_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               hit;
  } horner_t;

  // Directed row: optional coefficient load (a5..a0), sample time, typed result
  typedef struct {
    logic                         load;
    logic [NumCoef-1:0][DataW-1:0] coefs;
    logic [DataW-1:0]             t;
    logic                         typed;
    motion_t                      want;
  } vector_t;

  localparam logic [DataW-1:0] MaxQ  = 32'h7fff_ffff;
  localparam logic [DataW-1:0] MinQ  = 32'h8000_0000;
  localparam logic [DataW-1:0] OneQ  = 32'h0001_0000;
  localparam logic [DataW-1:0] ZeroQ = 32'h0000_0000;
  localparam int NumVectors    = 21;
  localparam int NumPhases     = 14;
  localparam int ItemsPerPhase = 100;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  reg_idx_e             cfg_idx_i     = REG_COEF_0;
  logic [DataW-1:0]     cfg_data_i    = '0;
  logic                 start         = 1'b0;
  logic                 busy;
  logic [DataW-1:0]     sample_time_i = '0;
  logic                 done_o;
  logic signed [DataW-1:0] position_o;
  logic signed [DataW-1:0] velocity_o;
  logic signed [DataW-1:0] acceleration_o;
  logic                 overflow_o;

  // Typed expectation for the next transfer, driven alongside start
  logic                 use_typed    = 1'b0;
  motion_t              typed_motion = '0;

  logic signed [63:0]   coef_q [NumCoef] = '{default: '0};
  motion_t              motion_q [$];
  int                   fault_count = 0;

  quintic_trajectory_evaluator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .sample_time_i  (sample_time_i),
    .done_o         (done_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Directed rows: reset state, extremes, rounding ties, inner and final clamps
  vector_t dir_vectors [NumVectors] = '{
    '{1'b0, '0, ZeroQ, 1'b1, '{ZeroQ, ZeroQ, ZeroQ, 1'b0}},
    '{1'b0, '0, MaxQ, 1'b1, '{ZeroQ, ZeroQ, ZeroQ, 1'b0}},
    '{1'b0, '0, MinQ, 1'b1, '{ZeroQ, ZeroQ, ZeroQ, 1'b0}},
    '{1'b1, {ZeroQ, ZeroQ, ZeroQ, ZeroQ, ZeroQ, MaxQ}, MinQ, 1'b1,
      '{MaxQ, ZeroQ, ZeroQ, 1'b0}},
    '{1'b1, {MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ}, MaxQ, 1'b1,
      '{MaxQ, MaxQ, MaxQ, 1'b1}},
    '{1'b0, '0, MinQ, 1'b0, '0},
    '{1'b0, '0, ZeroQ, 1'b1, '{MaxQ, MaxQ, MaxQ, 1'b1}},
    '{1'b1, {MinQ, MinQ, MinQ, MinQ, MinQ, MinQ}, MaxQ, 1'b1,
      '{MinQ, MinQ, MinQ, 1'b1}},
    '{1'b0, '0, MinQ, 1'b0, '0},
    // a1 is one LSB: the half-LSB product shows the rounding direction
    '{1'b1, {ZeroQ, ZeroQ, ZeroQ, ZeroQ, 32'h1, ZeroQ}, 32'h0000_8000, 1'b1,
      '{32'h1, 32'h1, ZeroQ, 1'b0}},
    '{1'b0, '0, 32'hffff_8000, 1'b1, '{ZeroQ, 32'h1, ZeroQ, 1'b0}},
    '{1'b0, '0, 32'h0000_7fff, 1'b1, '{ZeroQ, 32'h1, ZeroQ, 1'b0}},
    '{1'b0, '0, 32'hffff_7fff, 1'b1, '{32'hffff_ffff, 32'h1, ZeroQ, 1'b0}},
    // 5*a5 clamps inside Horner although every output is in range
    '{1'b1, {32'h4000_0000, ZeroQ, ZeroQ, ZeroQ, ZeroQ, ZeroQ}, ZeroQ, 1'b1,
      '{ZeroQ, ZeroQ, ZeroQ, 1'b1}},
    '{1'b0, '0, OneQ, 1'b0, '0},
    // 2*a2 clamps on the final acceleration
    '{1'b1, {ZeroQ, ZeroQ, ZeroQ, MaxQ, ZeroQ, ZeroQ}, ZeroQ, 1'b1,
      '{ZeroQ, ZeroQ, MaxQ, 1'b1}},
    '{1'b1, {ZeroQ, ZeroQ, ZeroQ, MinQ, ZeroQ, ZeroQ}, ZeroQ, 1'b1,
      '{ZeroQ, ZeroQ, MinQ, 1'b1}},
    '{1'b1, {OneQ, OneQ, OneQ, OneQ, OneQ, OneQ}, OneQ, 1'b1,
      '{32'h0006_0000, 32'h000f_0000, 32'h0028_0000, 1'b0}},
    '{1'b0, '0, 32'hffff_0000, 1'b1,
      '{ZeroQ, 32'h0003_0000, 32'hfff4_0000, 1'b0}},
    '{1'b0, '0, 32'h0002_0000, 1'b0, '0},
    '{1'b0, '0, 32'h0001_8000, 1'b0, '0}
  };

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  // Horner from c[top] down to c[0], clamping before every multiply
  function automatic horner_t eval_horner(input logic [NumCoef-1:0][63:0] c,
                                          input int top,
                                          input logic signed [63:0] t);
    horner_t r;
    logic signed [63:0] a, m, p;
    int i;
    r.hit = 1'b0;
    a = $signed(c[top]);
    for (i = top - 1; i >= 0; i--) begin
      m = clamp_q(a);
      if (m != a) r.hit = 1'b1;
      p = m * t + (64'sd1 <<< (FracBitsDefault - 1));
      a = (p >>> FracBitsDefault) + $signed(c[i]);
    end
    r.val = clamp_q(a);
    if (r.val != a) r.hit = 1'b1;
    return r;
  endfunction

  // Position, velocity and acceleration at one sample time
  function automatic motion_t predict_motion(input logic [DataW-1:0] t_in);
    logic [NumCoef-1:0][63:0] pc, vc, ac;
    logic signed [63:0] t;
    horner_t hp, hv, ha;
    motion_t r;
    t = $signed(t_in);
    vc = '0;
    ac = '0;
    for (int i = 0; i < NumCoef; i++) pc[i] = coef_q[i];
    vc[0] = coef_q[1];
    vc[1] = 2 * coef_q[2];
    vc[2] = 3 * coef_q[3];
    vc[3] = 4 * coef_q[4];
    vc[4] = 5 * coef_q[5];
    ac[0] = 2 * coef_q[2];
    ac[1] = 6 * coef_q[3];
    ac[2] = 12 * coef_q[4];
    ac[3] = 20 * coef_q[5];
    hp = eval_horner(pc, 5, t);
    hv = eval_horner(vc, 4, t);
    ha = eval_horner(ac, 3, t);
    r.pos = hp.val[DataW-1:0];
    r.vel = hv.val[DataW-1:0];
    r.acc = ha.val[DataW-1:0];
    r.ovf = hp.hit | hv.hit | ha.hit;
    return r;
  endfunction

  // Random value sign-extended from a random width, so small and huge both occur
  function automatic logic [DataW-1:0] rand_span();
    logic [DataW-1:0] v;
    int unsigned w;
    v = $urandom;
    w = $urandom_range(1, DataW);
    return $signed(v << (DataW - w)) >>> (DataW - w);
  endfunction

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("tb_top: %s", what);
  endtask

  // Result checker, coefficient shadow and expectation capture
  always @(posedge clk_i) begin : check_p
    motion_t got, want;
    if (rst_ni) begin
      if (done_o) begin
        got = {position_o, velocity_o, acceleration_o, overflow_o};
        if (motion_q.size() == 0) begin
          note_fault($sformatf("unexpected result pos %h vel %h acc %h ovf %b",
                               got.pos, got.vel, got.acc, got.ovf));
        end else begin
          want = motion_q.pop_front();
          if (got.pos !== want.pos || got.vel !== want.vel ||
              got.acc !== want.acc || got.ovf !== want.ovf) begin
            note_fault($sformatf(
              "mismatch pos %h/%h vel %h/%h acc %h/%h ovf %b/%b (exp/got)",
              want.pos, got.pos, want.vel, got.vel, want.acc, got.acc,
              want.ovf, got.ovf));
          end
        end
      end
      if (cfg_we_i && cfg_idx_i <= REG_COEF_5) begin
        coef_q[cfg_idx_i] = $signed(cfg_data_i);
      end
      if (start && !busy) begin
        motion_q.insert(motion_q.size(),
                        use_typed ? typed_motion : predict_motion(sample_time_i));
      end
    end
  end

  // Hold start high until a transfer; the caller lowers it
  task automatic issue_sample(input logic [DataW-1:0] t, input logic typed,
                              input motion_t val);
    start         <= 1'b1;
    sample_time_i <= t;
    use_typed     <= typed;
    typed_motion  <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // Caller has lowered start; one edge first so the last capture is queued
  task automatic wait_all_results();
    @(posedge clk_i);
    while (motion_q.size() != 0) @(posedge clk_i);
  endtask

  // All six coefficients, then one write to a dropped index
  task automatic load_coefs(input logic [NumCoef-1:0][DataW-1:0] c);
    reg_idx_e idx;
    idx = REG_COEF_0;
    do begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= c[idx];
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != REG_SPARE_6);
    cfg_idx_i  <= ($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7;
    cfg_data_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [NumCoef-1:0][DataW-1:0] c;
    int phase, sent, burst;
    bit steady;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_vectors[i]) begin
      if (dir_vectors[i].load) begin
        start <= 1'b0;
        wait_all_results();
        load_coefs(dir_vectors[i].coefs);
      end
      issue_sample(dir_vectors[i].t, dir_vectors[i].typed, dir_vectors[i].want);
    end

    // Random phases: new coefficients once idle, then bursts of sample times
    for (phase = 0; phase < NumPhases; phase++) begin
      start <= 1'b0;
      wait_all_results();
      for (int i = 0; i < NumCoef; i++) begin
        case (phase)
          0:       c[i] = MaxQ;
          1:       c[i] = MinQ;
          default: c[i] = rand_span();
        endcase
      end
      load_coefs(c);
      steady = (phase % 4 == 3);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        burst = $urandom_range(1, 24);
        if (burst > ItemsPerPhase - sent) burst = ItemsPerPhase - sent;
        repeat (burst) begin
          issue_sample(rand_span(), 1'b0, '0);
          sent++;
        end
        if (!steady) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end

    start <= 1'b0;
    wait_all_results();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && motion_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
